// ===== src/assert_macros.svh =====
// assertion macros for the rtl top level of the blur line block
// no dependencies; expects clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define GATBL_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("gatbl assertion failed");

// next-cycle implication, checked outside reset
`define GATBL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gatbl assertion failed");

`endif

// ===== src/gatbl_pkg.sv =====
// shared constants and types for the three-box blur line
// no dependencies
package gatbl_pkg;

  localparam int MAX_RADIUS_DEF  = 9;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SIGMA_BITS      = 4;

  // window control handed from a stage to its tap cells
  typedef struct packed {
    logic fill;   // line start: every tap takes the new value
    logic shift;  // normal push: taps move one place along
  } cell_ctrl_t;

  // control part of an item between stages
  typedef struct packed {
    logic valid;
    logic last;
  } link_t;

endpackage

// ===== src/gatbl_cell.sv =====
// one tap of a box window: loads on line start, takes its neighbor on a shift, else holds
// depends on gatbl_pkg
module gatbl_cell #(
  parameter int SAMPLE_BITS = gatbl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  gatbl_pkg::cell_ctrl_t   ctrl,
  input  logic [SAMPLE_BITS-1:0]  fill_val,
  input  logic [SAMPLE_BITS-1:0]  prev_val,
  output logic [SAMPLE_BITS-1:0]  tap
);

  always_ff @(posedge clk) begin
    if (ctrl.fill) begin
      tap <= fill_val;
    end else if (ctrl.shift) begin
      tap <= prev_val;
    end
  end

endmodule

// ===== src/gatbl_stage.sv =====
// one box filter stage: tap chain, running sum, edge flush, rounded divide
// depends on gatbl_pkg and gatbl_cell
module gatbl_stage #(
  parameter int MAX_RADIUS  = gatbl_pkg::MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = gatbl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                use_hi,
  input  gatbl_pkg::link_t                    in_link,
  input  logic [SAMPLE_BITS-1:0]              in_data,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]     in_sig,
  output logic                                in_stall,
  output gatbl_pkg::link_t                    out_link,
  output logic [SAMPLE_BITS-1:0]              out_data,
  output logic [$clog2(MAX_RADIUS+1)-1:0]     out_sig,
  input  logic                                out_stall
);

  localparam int WIN_LEN  = 2 * MAX_RADIUS + 1;
  localparam int RB       = $clog2(MAX_RADIUS + 1);
  localparam int CW       = $clog2(WIN_LEN);
  localparam int NB       = $clog2(WIN_LEN + 1);
  localparam int PB       = $clog2(MAX_RADIUS + 2);
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(WIN_LEN);
  localparam int K        = SUM_BITS + NB;
  localparam int POS_CAP  = MAX_RADIUS + 1;

  // control
  logic [PB-1:0]           pos;
  logic                    flushing;
  logic [RB-1:0]           flush_cnt;
  logic [RB-1:0]           r_line;
  logic [RB-1:0]           sig_line;
  logic [SAMPLE_BITS-1:0]  edge_val;
  logic [SUM_BITS-1:0]     sum;

  // emit register and output register
  logic                    a_valid;
  logic [SUM_BITS-1:0]     a_sum;
  logic [RB-1:0]           a_r;
  logic                    a_last;
  logic [RB-1:0]           a_sig;
  logic                    b_valid;
  logic [SAMPLE_BITS-1:0]  b_data;
  logic                    b_last;
  logic [RB-1:0]           b_sig;

  logic                    b_adv, a_ready, in_take, flush_push, push, start_push;
  logic [RB-1:0]           r_in, eff_r, eff_sig;
  logic [SAMPLE_BITS-1:0]  v;
  logic [NB-1:0]           n_eff;
  logic [NB+SAMPLE_BITS-1:0] fill_sum;
  logic [SUM_BITS-1:0]     sum_next;
  logic [PB-1:0]           pos_inc;
  logic                    emit, item_last, line_done;
  logic [SAMPLE_BITS-1:0]  old;
  logic [SAMPLE_BITS-1:0]  win [WIN_LEN];
  gatbl_pkg::cell_ctrl_t   cctrl;
  logic [K:0]              recip_tab [MAX_RADIUS+1];
  logic [SUM_BITS-1:0]     div_x;
  logic [SUM_BITS+K:0]     div_prod;

  // handshake
  assign b_adv      = !b_valid || !out_stall;
  assign a_ready    = !a_valid || b_adv;
  assign in_stall   = flushing || !a_ready;
  assign in_take    = in_link.valid && !in_stall;
  assign flush_push = flushing && a_ready;
  assign push       = in_take || flush_push;
  assign start_push = in_take && (pos == '0);

  // radius of this stage for the line
  assign r_in    = use_hi ? in_sig : ((in_sig == '0) ? '0 : in_sig - RB'(1));
  assign eff_r   = start_push ? r_in : r_line;
  assign eff_sig = start_push ? in_sig : sig_line;
  assign v       = flushing ? edge_val : in_data;
  assign n_eff   = NB'({eff_r, 1'b0}) + NB'(1);
  assign old     = win[CW'({eff_r, 1'b0})];

  assign fill_sum = n_eff * v;
  assign sum_next = start_push ? SUM_BITS'(fill_sum)
                               : SUM_BITS'(sum - SUM_BITS'(old) + SUM_BITS'(v));

  assign pos_inc  = (pos == '0) ? PB'(1) : ((pos == PB'(POS_CAP)) ? pos : pos + PB'(1));
  assign emit     = pos_inc > PB'(eff_r);
  assign item_last = in_take ? (in_link.last && (eff_r == '0)) : (flush_cnt == r_line);
  assign line_done = (in_take && in_link.last && (eff_r == '0)) ||
                     (flush_push && (flush_cnt == r_line));

  // tap chain
  assign cctrl.fill  = push && start_push;
  assign cctrl.shift = push && !start_push;

  for (genvar i = 0; i < WIN_LEN; i++) begin : g_tap
    if (i == 0) begin : g_head
      gatbl_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk(clk), .ctrl(cctrl), .fill_val(v), .prev_val(v), .tap(win[i])
      );
    end else begin : g_body
      gatbl_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk(clk), .ctrl(cctrl), .fill_val(v), .prev_val(win[i-1]), .tap(win[i])
      );
    end
  end

  // reciprocals of 2r+1, rounded up, exact for every sum that can occur
  // one bit wider than K so that radius zero keeps its full scale of 2^K
  for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_recip
    localparam logic [63:0] M = ((64'd1 << K) + 64'(2 * g)) / 64'(2 * g + 1);
    assign recip_tab[g] = (K+1)'(M);
  end

  assign div_x    = SUM_BITS'(a_sum + SUM_BITS'(a_r));
  assign div_prod = div_x * recip_tab[a_r];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      flushing <= 1'b0;
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
    end else begin
      if (push) begin
        if (line_done) begin
          pos      <= '0;
          flushing <= 1'b0;
        end else begin
          pos <= pos_inc;
          if (in_take && in_link.last) begin
            flushing <= 1'b1;
          end
        end
      end
      if (a_ready) begin
        a_valid <= push && emit;
      end
      if (b_adv) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      sum <= sum_next;
    end
    if (flush_push) begin
      flush_cnt <= flush_cnt + RB'(1);
    end
    if (in_take) begin
      edge_val  <= in_data;
      flush_cnt <= RB'(1);
      if (start_push) begin
        r_line   <= r_in;
        sig_line <= in_sig;
      end
    end
    if (a_ready) begin
      a_sum  <= sum_next;
      a_r    <= eff_r;
      a_last <= item_last;
      a_sig  <= eff_sig;
    end
    if (b_adv) begin
      b_data <= div_prod[K +: SAMPLE_BITS];
      b_last <= a_last;
      b_sig  <= a_sig;
    end
  end

  assign out_link.valid = b_valid;
  assign out_link.last  = b_last;
  assign out_data       = b_data;
  assign out_sig        = b_sig;

endmodule

// ===== src/gaussian_approx_triple_box_line.sv =====
// top level of the three-box gaussian blur along one line of samples
// depends on gatbl_pkg, gatbl_stage, gatbl_cell and assert_macros.svh
//
// usage
// - input channel: sample_in and row_end_in, taken when in_valid is high and
//   in_stall is low; row_end_in marks the last sample of a line
// - output channel: sample_out and row_end_out, taken when out_valid is high
//   and out_stall is low; a line of w samples gives exactly w results
// - sigma (0..9, larger values act as 9) is written through cfg_write and
//   cfg_data; it is latched at the first sample of a line, so a write in
//   the middle of a line applies from the next line on
// - radii are s-1, s-1, s for sigma s (all zero for sigma 0)
// - throughput: one item per cycle inside a line unless a stall holds it; at
//   a line end each stage pushes its edge sample r more times and takes no
//   input meanwhile, so with lines back to back the third stage sets the pace
// - pipeline: two registers per stage, emit and output; a result leaves them
//   after the sample that completes its window, r0+r1+r2 samples later
// - reset clears sigma and all line positions; the next sample starts a line
// - out_stall holds the last stage; the stall walks back stage by stage
//   and in_stall rises once every stage register in between is full
`include "assert_macros.svh"

module gaussian_approx_triple_box_line #(
  parameter int MAX_RADIUS  = gatbl_pkg::MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = gatbl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gatbl_pkg::SIGMA_BITS-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [SAMPLE_BITS-1:0]           sample_in,
  input  logic                             row_end_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [SAMPLE_BITS-1:0]           sample_out,
  output logic                             row_end_out
);

  localparam int RB = $clog2(MAX_RADIUS + 1);

  // sigma register and clamp to the largest radius
  logic [gatbl_pkg::SIGMA_BITS-1:0] sigma_q;
  logic [RB-1:0]                    sig_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_q <= '0;
    end else if (cfg_write) begin
      sigma_q <= cfg_data;
    end
  end

  assign sig_clamped = (32'(sigma_q) > MAX_RADIUS) ? RB'(MAX_RADIUS) : RB'(sigma_q);

  // links between the three stages
  gatbl_pkg::link_t        l_in, l01, l12, l_out;
  logic [SAMPLE_BITS-1:0]  d01, d12;
  logic [RB-1:0]           s01, s12, s_out;
  logic                    st1_stall, st2_stall;

  assign l_in.valid = in_valid;
  assign l_in.last  = row_end_in;

  // first stage, radius s-1
  gatbl_stage #(.MAX_RADIUS(MAX_RADIUS), .SAMPLE_BITS(SAMPLE_BITS)) u_stage0 (
    .clk(clk), .rst(rst), .use_hi(1'b0),
    .in_link(l_in), .in_data(sample_in), .in_sig(sig_clamped), .in_stall(in_stall),
    .out_link(l01), .out_data(d01), .out_sig(s01), .out_stall(st1_stall)
  );

  // second stage, radius s-1
  gatbl_stage #(.MAX_RADIUS(MAX_RADIUS), .SAMPLE_BITS(SAMPLE_BITS)) u_stage1 (
    .clk(clk), .rst(rst), .use_hi(1'b0),
    .in_link(l01), .in_data(d01), .in_sig(s01), .in_stall(st1_stall),
    .out_link(l12), .out_data(d12), .out_sig(s12), .out_stall(st2_stall)
  );

  // third stage, radius s
  gatbl_stage #(.MAX_RADIUS(MAX_RADIUS), .SAMPLE_BITS(SAMPLE_BITS)) u_stage2 (
    .clk(clk), .rst(rst), .use_hi(1'b1),
    .in_link(l12), .in_data(d12), .in_sig(s12), .in_stall(st2_stall),
    .out_link(l_out), .out_data(sample_out), .out_sig(s_out), .out_stall(out_stall)
  );

  assign out_valid   = l_out.valid;
  assign row_end_out = l_out.last;

  // checks
  `GATBL_ASSERT_NOW(a_sigma_reset, $past(rst), sigma_q == '0)
  `GATBL_ASSERT_NOW(a_sig_range, 1'b1, 32'(sig_clamped) <= MAX_RADIUS)
  `GATBL_ASSERT_NEXT(a_link_hold, l01.valid && st1_stall, l01.valid && d01 == $past(d01))
  `GATBL_ASSERT_NOW(a_out_sig_range, out_valid, 32'(s_out) <= MAX_RADIUS)

endmodule

// ===== test/blur_line_checker.sv =====
// checker for the three-box blur line: watches the config, input and output
// channels, predicts blurred samples and compares them; depends on gatbl_pkg
module blur_line_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gatbl_pkg::SIGMA_BITS-1:0] cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [gatbl_pkg::SAMPLE_BITS_DEF-1:0] sample_in,
  input  logic                             row_end_in,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [gatbl_pkg::SAMPLE_BITS_DEF-1:0] sample_out,
  input  logic                             row_end_out,
  output int                               pending,
  output int                               errors,
  output int                               checked
);

  localparam int MAX_R = gatbl_pkg::MAX_RADIUS_DEF;
  localparam int SB    = gatbl_pkg::SAMPLE_BITS_DEF;
  localparam int WIN   = 2 * MAX_R + 1;

  typedef logic [SB-1:0] sample_t;
  typedef struct packed {
    sample_t value;
    logic    last;
  } blurred_t;
  typedef blurred_t blurred_q_t[$];

  // predictor state
  logic [gatbl_pkg::SIGMA_BITS-1:0] sigma_q;
  sample_t     win [3][WIN];
  logic [20:0] box_sum [3];
  sample_t     edge_val [3];
  logic [4:0]  fill_cnt [3];
  int unsigned radius [3];

  blurred_t blurred_expected[$];
  int       err_cnt;
  int       chk_cnt;

  function automatic void clear_predictor();
    sigma_q = '0;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < WIN; i++) win[k][i] = '0;
      box_sum[k]  = '0;
      edge_val[k] = '0;
      fill_cnt[k] = '0;
      radius[k]   = 0;
    end
  endfunction

  // one push into the window of stage k; returns 1 when the stage emits
  function automatic bit box_push(int k, sample_t v, output sample_t y);
    int unsigned r;
    int unsigned n;
    r = radius[k];
    n = 2 * r + 1;
    if (fill_cnt[k] == 0) begin
      for (int i = 0; i < n; i++) win[k][i] = v;
      box_sum[k] = 21'(n * v);
    end else begin
      box_sum[k] = box_sum[k] - win[k][0] + v;
      for (int i = 0; i < n - 1; i++) win[k][i] = win[k][i+1];
      win[k][n-1] = v;
    end
    if (fill_cnt[k] < MAX_R + 1) fill_cnt[k]++;
    y = '0;
    if (fill_cnt[k] > r) begin
      y = sample_t'((box_sum[k] + r) / n);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one sample into stage k; a line end pushes the edge sample r more times
  function automatic blurred_q_t box_stage(int k, sample_t x, bit last);
    blurred_q_t res;
    blurred_t   item;
    sample_t    y;
    int unsigned r;
    r = radius[k];
    edge_val[k] = x;
    if (box_push(k, x, y)) begin
      item.value = y;
      item.last  = last && (r == 0);
      res = {res, item};
    end
    if (last) begin
      for (int unsigned t = 1; t <= r; t++) begin
        if (box_push(k, edge_val[k], y)) begin
          item.value = y;
          item.last  = (t == r);
          res = {res, item};
        end
      end
      fill_cnt[k] = '0;
    end
    return res;
  endfunction

  function automatic void predict_blur(sample_t x, bit last);
    blurred_q_t a;
    blurred_q_t b;
    blurred_q_t c;
    int unsigned s;
    // radii latch at the first sample of a line
    if (fill_cnt[0] == 0) begin
      s = (sigma_q > MAX_R) ? MAX_R : sigma_q;
      radius[0] = (s == 0) ? 0 : s - 1;
      radius[1] = radius[0];
      radius[2] = s;
    end
    a = box_stage(0, x, last);
    foreach (a[i]) begin
      b = box_stage(1, a[i].value, a[i].last);
      foreach (b[j]) begin
        c = box_stage(2, b[j].value, b[j].last);
        foreach (c[m]) blurred_expected = {blurred_expected, c[m]};
      end
    end
  endfunction

  always @(posedge clk) begin
    blurred_t exp_item;
    if (rst) begin
      clear_predictor();
      blurred_expected.delete();
      err_cnt = 0;
      chk_cnt = 0;
    end else begin
      // an item taken at the same edge as a write still sees the old sigma
      if (in_valid && !in_stall) predict_blur(sample_in, row_end_in);
      if (cfg_write) sigma_q = cfg_data;
      if (out_valid && !out_stall) begin
        chk_cnt++;
        if (blurred_expected.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, got sample %0d row_end %0b",
                   $time, sample_out, row_end_out);
        end else begin
          exp_item = blurred_expected.pop_front();
          if (sample_out !== exp_item.value) begin
            err_cnt++;
            $display("%0t: sample_out mismatch: expected %0d, got %0d",
                     $time, exp_item.value, sample_out);
          end
          if (row_end_out !== exp_item.last) begin
            err_cnt++;
            $display("%0t: row_end_out mismatch: expected %0b, got %0b",
                     $time, exp_item.last, row_end_out);
          end
        end
      end
    end
    pending <= blurred_expected.size();
    errors  <= err_cnt;
    checked <= chk_cnt;
  end

endmodule

// ===== test/gaussian_approx_triple_box_line_tb.sv =====
// testbench top for the three-box gaussian blur line: drives lines of samples
// and sigma writes, verdict from blur_line_checker; depends on gatbl_pkg
module gaussian_approx_triple_box_line_tb;

  localparam int SB            = gatbl_pkg::SAMPLE_BITS_DEF;
  localparam int SIGMA_BITS    = gatbl_pkg::SIGMA_BITS;
  localparam int RANDOM_ITEMS  = 400;
  localparam int QUIET_TAIL    = 60;    // final items sent with no idling
  localparam int SETTLE_CYCLES = 40;    // stage registers plus edge pushes of three stages
  localparam int HOLD_CYCLES   = 150;   // long output hold-off
  localparam int CYCLE_LIMIT   = 400000;

  typedef logic [SB-1:0] sample_t;
  typedef enum int {PAT_NOISE, PAT_SMOOTH, PAT_EXTREME} pattern_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [SIGMA_BITS-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sample_t               sample_in = '0;
  logic                  row_end_in = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sample_t               sample_out;
  logic                  row_end_out;

  int pending;
  int errors;
  int checked;

  // stimulus bookkeeping and idling controls
  int items_sent = 0;
  int lines_sent = 0;
  int cycle_cnt  = 0;
  bit send_idle  = 1'b0;
  bit recv_idle  = 1'b0;
  bit quiet      = 1'b0;
  bit hold_req   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gaussian_approx_triple_box_line uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_in   (sample_in),
    .row_end_in  (row_end_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_out  (sample_out),
    .row_end_out (row_end_out)
  );

  blur_line_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_in   (sample_in),
    .row_end_in  (row_end_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_out  (sample_out),
    .row_end_out (row_end_out),
    .pending     (pending),
    .errors      (errors),
    .checked     (checked)
  );

  // offer one item and hold it until the block takes it; the payload never
  // changes while stalled and valid never looks at the stall
  task automatic send_sample(input sample_t s, input bit row_end);
    in_valid   <= 1'b1;
    sample_in  <= s;
    row_end_in <= row_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    // random sender gap while send_idle is set, none in the quiet tail
    if (send_idle && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // sender pause: wait until every predicted result has come out, then let
  // the pipe settle, since samples early in a line produce nothing yet
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sigma write, only ever issued with the block idle
  task automatic write_sigma(input logic [SIGMA_BITS-1:0] s);
    cfg_write <= 1'b1;
    cfg_data  <= s;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // a whole line with the row end mark on its last sample
  task automatic send_line(input int len, input pattern_e pat);
    sample_t v;
    v = sample_t'($urandom);
    for (int i = 0; i < len; i++) begin
      case (pat)
        PAT_NOISE:   v = sample_t'($urandom);
        PAT_SMOOTH:  v = v + sample_t'($urandom_range(0, 1024)) - sample_t'(512);
        PAT_EXTREME: v = $urandom_range(0, 1) ? '1 : '0;
        default:     v = sample_t'($urandom);
      endcase
      send_sample(v, i == len - 1);
    end
    lines_sent++;
  endtask

  function automatic int pick_length();
    int sel;
    sel = $urandom_range(0, 19);
    // mostly short lines, so line-end flushes and short-line clamping dominate
    if (sel < 13) return $urandom_range(1, 12);
    if (sel < 18) return $urandom_range(13, 40);
    return $urandom_range(41, 80);
  endfunction

  // receiver: random stall bursts, or one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (recv_idle && !quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int phase;
    int phase_items;
    int phase_goal;
    logic [SIGMA_BITS-1:0] s;
    pattern_e pat;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: sigma left at its reset value of zero, so samples pass through
    send_line(1, PAT_EXTREME);               // one-sample line
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(32768), 1'b1);

    // largest radii on lines shorter than a window: edges clamp on both sides
    drain_block();
    write_sigma(SIGMA_BITS'(9));
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    send_sample(sample_t'(12345), 1'b1);     // one-sample line at full blur

    // sigma above range acts as the largest setting
    drain_block();
    write_sigma('1);
    for (int i = 0; i < 5; i++) send_sample((i % 2) ? '1 : '0, i == 4);

    // sigma changed mid-line: the open line keeps its radii, the next one
    // picks up the new setting
    drain_block();
    write_sigma(SIGMA_BITS'(1));
    send_sample(sample_t'(100), 1'b0);
    send_sample(sample_t'(60000), 1'b0);
    send_sample(sample_t'(7), 1'b0);
    drain_block();
    write_sigma(SIGMA_BITS'(5));
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample(sample_t'(40000), 1'b1);
    for (int i = 0; i < 4; i++) send_sample(sample_t'($urandom), i == 3);

    // random phases: each starts from an idle block with a fresh sigma
    phase = 0;
    while (items_sent < RANDOM_ITEMS + 24) begin
      drain_block();
      case (phase)
        0:       s = '0;
        1:       s = SIGMA_BITS'(9);
        2:       s = '1;
        default: s = SIGMA_BITS'($urandom_range(0, 15));
      endcase
      write_sigma(s);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      quiet     = (items_sent >= RANDOM_ITEMS + 24 - QUIET_TAIL);
      phase_items = 0;
      phase_goal  = $urandom_range(20, 60);

      // long output hold while a long line keeps coming, so the block
      // fills up and has to stall its input
      if (phase == 1) begin
        hold_req = 1'b1;
        send_idle = 1'b0;
        send_line(60, PAT_NOISE);
        phase_items += 60;
      end

      while (phase_items < phase_goal) begin
        int len;
        len = pick_length();
        pat = pattern_e'($urandom_range(0, 2));
        quiet = quiet || (items_sent >= RANDOM_ITEMS + 24 - QUIET_TAIL);
        send_line(len, pat);
        phase_items += len;
      end
      phase++;
    end

    // wait for the last results, then a little extra for anything stray
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d samples in %0d lines over %0d sigma phases, %0d results compared",
             items_sent, lines_sent, phase, checked);
    $display("sigma included 0, 9 and clamped 15, a mid-line change and a long output hold");
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
